[src/vision_frame_receiver_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef VISION_FRAME_RECEIVER_UNIT_MACROS_SVH
`define VISION_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication
`define VFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/vfr_pkg.sv]
// ---------------------------------------------------------------------------
// vfr_pkg
// Constants and types shared by the frame receiver modules.
// ---------------------------------------------------------------------------
package vfr_pkg;

    localparam logic [7:0] FRAME_HEADER = 8'hAA;
    localparam logic [7:0] LENGTH_LIMIT = 8'd250;
    localparam logic [7:0] VISION_IDENT = 8'hF1;

    localparam logic CFG_OWN_ADDR   = 1'b0;
    localparam logic CFG_BCAST_ADDR = 1'b1;

    localparam logic [7:0] FUNC_LINE    = 8'd0;
    localparam logic [7:0] FUNC_X       = 8'd1;
    localparam logic [7:0] FUNC_Y       = 8'd2;
    localparam logic [7:0] FUNC_ARRIVED = 8'd3;

    typedef logic [3:0][7:0] t_window;

    // one finished frame handed from parser to record stage
    typedef struct packed {
        logic    sum_ok;
        logic    apply;
        t_window window;
    } t_frame_done;

endpackage

[src/vision_frame_receiver_unit.sv]
// ---------------------------------------------------------------------------
// vision_frame_receiver_unit
// Framed vision message receiver, one serial byte per word.
// ---------------------------------------------------------------------------
// Input words (i_rx_byte) go in with push/full; one byte per cycle is taken.
// The parser checks header, address, id and length, keeps both running sums
// and hands each completed frame (second sum byte) to a short frame queue.
// The record stage pops that queue, applies function-code updates for valid
// vision frames and shows one result word on empty/pop.
// A frame's result goes through the frame queue and the record register.
// Throughput: one byte per cycle; full rises only on a frame's last byte
// while the frame queue (FRAME_DEPTH entries) is full.
// A stalled receiver holds its result; up to FRAME_DEPTH more frames queue,
// and any number of non-final bytes keep flowing.
// Configuration (own/broadcast address) via cfg_valid/cfg_ready, always
// ready; write only while idle.
// Synchronous active-low reset clears parser, window bytes, record and
// queue; own address 0, broadcast address 255.
// ---------------------------------------------------------------------------
module vision_frame_receiver_unit #(
    parameter int FRAME_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_sum_ok,
    output logic [7:0]  o_turn_code,
    output logic [7:0]  o_line_angle,
    output logic [7:0]  o_x_direction,
    output logic [15:0] o_x_shift,
    output logic [7:0]  o_y_direction,
    output logic [15:0] o_y_shift,
    output logic [7:0]  o_arrived_flag,
    output logic [15:0] o_updates_seen,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    vfr_pkg::t_frame_done q_in_word, q_head;
    logic                 q_push, q_full, q_pop, q_empty;

    assign o_cfg_ready = 1'b1;

    vfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_rx_byte   (i_rx_byte),
        .o_full      (full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_word    (q_in_word)
    );

    vfr_fifo #(
        .DEPTH (FRAME_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in_word),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    vfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_head       (q_head),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_sum_ok       (o_sum_ok),
        .o_turn_code    (o_turn_code),
        .o_line_angle   (o_line_angle),
        .o_x_direction  (o_x_direction),
        .o_x_shift      (o_x_shift),
        .o_y_direction  (o_y_direction),
        .o_y_shift      (o_y_shift),
        .o_arrived_flag (o_arrived_flag),
        .o_updates_seen (o_updates_seen)
    );

endmodule

[src/vfr_front.sv]
// ---------------------------------------------------------------------------
// vfr_front
// Byte parser: header, address, id, length, payload, sum bytes.
// ---------------------------------------------------------------------------
module vfr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_full,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output vfr_pkg::t_frame_done o_q_word
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_ADDR,
        PH_IDENT,
        PH_PAYLOAD,
        PH_SUM1,
        PH_SUM2
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_bytes_left, n_bytes_left;
    logic [2:0]       r_pidx, n_pidx;
    logic [7:0]       r_sum1, n_sum1;
    logic [7:0]       r_sum2, n_sum2;
    logic [7:0]       r_got1, n_got1;
    logic             r_ident_ok, n_ident_ok;
    vfr_pkg::t_window r_win, n_win;
    logic [7:0]       r_own_addr, r_bcast_addr;
    logic             accept;
    logic [7:0]       add1;

    assign o_full   = (r_phase == PH_SUM2) && i_q_full;
    assign accept   = i_push && !o_full;
    assign add1     = r_sum1 + i_rx_byte;
    assign o_q_push = accept && (r_phase == PH_SUM2);

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_pidx       = r_pidx;
        n_sum1       = r_sum1;
        n_sum2       = r_sum2;
        n_got1       = r_got1;
        n_ident_ok   = r_ident_ok;
        n_win        = r_win;
        if (accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_rx_byte == vfr_pkg::FRAME_HEADER) begin
                        n_phase = PH_HDR;
                        n_sum1  = i_rx_byte;
                        n_sum2  = i_rx_byte;
                    end
                end
                PH_HDR: begin
                    if (i_rx_byte == r_own_addr || i_rx_byte == r_bcast_addr) begin
                        n_phase = PH_ADDR;
                        n_sum1  = add1;
                        n_sum2  = r_sum2 + add1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_ADDR: begin
                    n_phase    = PH_IDENT;
                    n_ident_ok = (i_rx_byte == vfr_pkg::VISION_IDENT);
                    n_sum1     = add1;
                    n_sum2     = r_sum2 + add1;
                end
                PH_IDENT: begin
                    if (i_rx_byte < vfr_pkg::LENGTH_LIMIT) begin
                        n_phase      = PH_PAYLOAD;
                        n_bytes_left = i_rx_byte;
                        n_pidx       = '0;
                        n_sum1       = add1;
                        n_sum2       = r_sum2 + add1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_bytes_left != 8'd0) begin
                        n_bytes_left = r_bytes_left - 8'd1;
                        if (!r_pidx[2]) begin
                            n_win[r_pidx[1:0]] = i_rx_byte;
                            n_pidx             = r_pidx + 3'd1;
                        end
                        n_sum1 = add1;
                        n_sum2 = r_sum2 + add1;
                        if (r_bytes_left == 8'd1) begin
                            n_phase = PH_SUM1;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_SUM1: begin
                    n_phase = PH_SUM2;
                    n_got1  = i_rx_byte;
                    if (!r_pidx[2]) begin
                        n_win[r_pidx[1:0]] = i_rx_byte;
                        n_pidx             = r_pidx + 3'd1;
                    end
                end
                PH_SUM2: begin
                    n_phase = PH_IDLE;
                    if (!r_pidx[2]) begin
                        n_win[r_pidx[1:0]] = i_rx_byte;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_q_word.sum_ok = (r_got1 == r_sum1) && (i_rx_byte == r_sum2);
        o_q_word.apply  = o_q_word.sum_ok && r_ident_ok;
        o_q_word.window = n_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_left <= '0;
            r_pidx       <= '0;
            r_sum1       <= '0;
            r_sum2       <= '0;
            r_got1       <= '0;
            r_ident_ok   <= 1'b0;
            r_win        <= '0;
            r_own_addr   <= 8'd0;
            r_bcast_addr <= 8'd255;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_pidx       <= n_pidx;
            r_sum1       <= n_sum1;
            r_sum2       <= n_sum2;
            r_got1       <= n_got1;
            r_ident_ok   <= n_ident_ok;
            r_win        <= n_win;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    vfr_pkg::CFG_OWN_ADDR:   r_own_addr   <= i_cfg_data;
                    vfr_pkg::CFG_BCAST_ADDR: r_bcast_addr <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[src/vfr_fifo.sv]
// ---------------------------------------------------------------------------
// vfr_fifo
// Short queue of finished frames between parser and record stage.
// ---------------------------------------------------------------------------
`include "vision_frame_receiver_unit_macros.svh"

module vfr_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  vfr_pkg::t_frame_done i_word,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output vfr_pkg::t_frame_done o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    vfr_pkg::t_frame_done r_mem [DEPTH];
    logic [AW-1:0]        r_wr, r_rd;
    logic [CW-1:0]        r_count;
    logic                 do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `VFR_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "queue count exceeds depth")
    `VFR_ASSERT_NOW(a_no_overflow, i_push, !o_full, "frame pushed into full queue")
    `VFR_ASSERT_NEXT(a_push_shows, o_empty && i_push, !o_empty, "pushed frame not visible")

endmodule

[src/vfr_back.sv]
// ---------------------------------------------------------------------------
// vfr_back
// Record stage: applies frame updates and holds the result word.
// ---------------------------------------------------------------------------
`include "vision_frame_receiver_unit_macros.svh"

module vfr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  vfr_pkg::t_frame_done i_q_head,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic                 o_sum_ok,
    output logic [7:0]           o_turn_code,
    output logic [7:0]           o_line_angle,
    output logic [7:0]           o_x_direction,
    output logic [15:0]          o_x_shift,
    output logic [7:0]           o_y_direction,
    output logic [15:0]          o_y_shift,
    output logic [7:0]           o_arrived_flag,
    output logic [15:0]          o_updates_seen
);

    logic             r_valid;
    logic             r_sum_ok;
    logic [7:0]       r_turn, r_angle, r_xdir, r_ydir, r_arrived;
    logic [15:0]      r_xshift, r_yshift, r_tally;
    logic             take;
    vfr_pkg::t_window w;

    assign take    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = take;
    assign w       = i_q_head.window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_sum_ok  <= 1'b0;
            r_turn    <= '0;
            r_angle   <= '0;
            r_xdir    <= '0;
            r_xshift  <= '0;
            r_ydir    <= '0;
            r_yshift  <= '0;
            r_arrived <= '0;
            r_tally   <= '0;
        end else if (take) begin
            r_valid  <= 1'b1;
            r_sum_ok <= i_q_head.sum_ok;
            if (i_q_head.apply) begin
                case (w[0])
                    vfr_pkg::FUNC_LINE: begin
                        r_turn  <= w[1];
                        r_angle <= w[2];
                        r_tally <= r_tally + 16'd1;
                    end
                    vfr_pkg::FUNC_X: begin
                        r_xdir   <= w[1];
                        r_xshift <= {w[2], w[3]};
                        r_tally  <= r_tally + 16'd1;
                    end
                    vfr_pkg::FUNC_Y: begin
                        r_ydir   <= w[1];
                        r_yshift <= {w[2], w[3]};
                        r_tally  <= r_tally + 16'd1;
                    end
                    vfr_pkg::FUNC_ARRIVED: begin
                        r_arrived <= w[1];
                    end
                    default: begin
                    end
                endcase
            end
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_empty        = !r_valid;
    assign o_sum_ok       = r_sum_ok;
    assign o_turn_code    = r_turn;
    assign o_line_angle   = r_angle;
    assign o_x_direction  = r_xdir;
    assign o_x_shift      = r_xshift;
    assign o_y_direction  = r_ydir;
    assign o_y_shift      = r_yshift;
    assign o_arrived_flag = r_arrived;
    assign o_updates_seen = r_tally;

    `VFR_ASSERT_NEXT(a_take_shows, take, r_valid, "taken frame not presented")
    `VFR_ASSERT_NEXT(a_hold_word, r_valid && !i_pop, r_valid && $stable(r_tally),
        "waiting result word changed")

endmodule

[verif/tb_vision_frame_receiver_unit.sv]
// ---------------------------------------------------------------------------
// tb_vision_frame_receiver_unit
// Self-checking bench for the framed vision message receiver.
// ---------------------------------------------------------------------------
// A clocked driver feeds received bytes from a pending queue; a clocked
// monitor pops result words and checks them field by field against a
// byte-level parser model kept in the bench. Directed frames cover the
// corner cases, then random well-formed, broken and noise traffic runs
// over several address settings and sender/receiver idle mixes.
// ---------------------------------------------------------------------------
module tb_vision_frame_receiver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int PHASE_BYTES = 100;
    localparam int NUM_PHASES  = 5;

    typedef enum logic [2:0] {
        ST_IDLE, ST_HDR, ST_ADDR, ST_IDENT, ST_BODY, ST_SUM1, ST_SUM2
    } t_parse_st;

    typedef struct packed {
        logic        sum_ok;
        logic [7:0]  turn_code;
        logic [7:0]  line_angle;
        logic [7:0]  x_direction;
        logic [15:0] x_shift;
        logic [7:0]  y_direction;
        logic [15:0] y_shift;
        logic [7:0]  arrived_flag;
        logic [15:0] updates_seen;
    } t_frame_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_sum_ok;
    logic [7:0]  o_turn_code;
    logic [7:0]  o_line_angle;
    logic [7:0]  o_x_direction;
    logic [15:0] o_x_shift;
    logic [7:0]  o_y_direction;
    logic [15:0] o_y_shift;
    logic [7:0]  o_arrived_flag;
    logic [15:0] o_updates_seen;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = vfr_pkg::CFG_OWN_ADDR;
    logic [7:0]  i_cfg_data = 8'h00;

    vision_frame_receiver_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_sum_ok       (o_sum_ok),
        .o_turn_code    (o_turn_code),
        .o_line_angle   (o_line_angle),
        .o_x_direction  (o_x_direction),
        .o_x_shift      (o_x_shift),
        .o_y_direction  (o_y_direction),
        .o_y_shift      (o_y_shift),
        .o_arrived_flag (o_arrived_flag),
        .o_updates_seen (o_updates_seen),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stimulus and expectations
    logic [7:0]    pending_bytes [$];
    logic [7:0]    frame_bytes [$];
    t_frame_report expected_reports [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int bytes_taken = 0;
    int reports_taken = 0;
    int regs_written = 0;
    int last_seen = 0;
    int quiet_cycles = 0;

    // parser model
    logic [7:0]       own_addr = 8'h00;
    logic [7:0]       bcast_addr = 8'hFF;
    t_parse_st        pstate = ST_IDLE;
    logic [7:0]       left_cnt = '0;
    logic [7:0]       tail_idx = '0;
    logic [7:0]       run1 = '0;
    logic [7:0]       run2 = '0;
    logic [7:0]       sum1_rx = '0;
    logic [7:0]       ident_q = '0;
    vfr_pkg::t_window win = '0;
    t_frame_report    rec = '0;

    logic [7:0] own_tab   [0:NUM_PHASES-1] = '{8'h00, 8'hFF, 8'h3C, 8'hAA, 8'h5A};
    logic [7:0] bcast_tab [0:NUM_PHASES-1] = '{8'hFF, 8'h00, 8'hC3, 8'hAA, 8'hFF};
    int         send_tab  [0:NUM_PHASES-1] = '{0, 60, 0, 32, 0};
    int         recv_tab  [0:NUM_PHASES-1] = '{0, 0, 60, 32, 0};

    task automatic sum_in(input logic [7:0] b);
        run1 = run1 + b;
        run2 = run2 + run1;
    endtask

    task automatic keep_tail(input logic [7:0] b);
        if (tail_idx < 8'd4) win[tail_idx[1:0]] = b;
        tail_idx = tail_idx + 8'd1;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        logic good;
        if (pstate == ST_IDLE && b == vfr_pkg::FRAME_HEADER) begin
            pstate = ST_HDR;
            run1 = '0;
            run2 = '0;
            sum_in(b);
        end else if (pstate == ST_HDR && (b == own_addr || b == bcast_addr)) begin
            pstate = ST_ADDR;
            sum_in(b);
        end else if (pstate == ST_ADDR) begin
            pstate = ST_IDENT;
            ident_q = b;
            sum_in(b);
        end else if (pstate == ST_IDENT && b < vfr_pkg::LENGTH_LIMIT) begin
            pstate = ST_BODY;
            left_cnt = b;
            tail_idx = '0;
            sum_in(b);
        end else if (pstate == ST_BODY && left_cnt != 8'd0) begin
            left_cnt = left_cnt - 8'd1;
            keep_tail(b);
            sum_in(b);
            if (left_cnt == 8'd0) pstate = ST_SUM1;
        end else if (pstate == ST_SUM1) begin
            pstate = ST_SUM2;
            sum1_rx = b;
            keep_tail(b);
        end else if (pstate == ST_SUM2) begin
            pstate = ST_IDLE;
            if (tail_idx < 8'd4) win[tail_idx[1:0]] = b;
            good = (sum1_rx == run1) && (b == run2);
            if (good && ident_q == vfr_pkg::VISION_IDENT) begin
                case (win[0])
                    vfr_pkg::FUNC_LINE: begin
                        rec.turn_code    = win[1];
                        rec.line_angle   = win[2];
                        rec.updates_seen = rec.updates_seen + 16'd1;
                    end
                    vfr_pkg::FUNC_X: begin
                        rec.x_direction  = win[1];
                        rec.x_shift      = {win[2], win[3]};
                        rec.updates_seen = rec.updates_seen + 16'd1;
                    end
                    vfr_pkg::FUNC_Y: begin
                        rec.y_direction  = win[1];
                        rec.y_shift      = {win[2], win[3]};
                        rec.updates_seen = rec.updates_seen + 16'd1;
                    end
                    vfr_pkg::FUNC_ARRIVED: begin
                        rec.arrived_flag = win[1];
                    end
                    default: ;
                endcase
            end
            rec.sum_ok = good;
            expected_reports.push_back(rec);
        end else begin
            pstate = ST_IDLE;
        end
    endtask

    task automatic make_frame(input logic [7:0] addr, input logic [7:0] id,
                              input logic [7:0] len, input logic [7:0] func,
                              input bit corrupt);
        logic [7:0] a;
        logic [7:0] b;
        int i;
        frame_bytes.delete();
        frame_bytes.push_back(vfr_pkg::FRAME_HEADER);
        frame_bytes.push_back(addr);
        frame_bytes.push_back(id);
        frame_bytes.push_back(len);
        for (i = 0; i < int'(len); i++)
            frame_bytes.push_back(i == 0 ? func : 8'($urandom));
        a = '0;
        b = '0;
        foreach (frame_bytes[j]) begin
            a = a + frame_bytes[j];
            b = b + a;
        end
        if (corrupt) begin
            if ($urandom_range(1) == 0) a = a ^ 8'($urandom_range(255, 1));
            else b = b ^ 8'($urandom_range(255, 1));
        end
        frame_bytes.push_back(a);
        frame_bytes.push_back(b);
    endtask

    task automatic enqueue_frame(input int upto);
        int k;
        for (k = 0; k < upto; k++) pending_bytes.push_back(frame_bytes[k]);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        if (idx == vfr_pkg::CFG_OWN_ADDR) own_addr = val;
        else bcast_addr = val;
        regs_written++;
    endtask

    // drain, then flush the parser back to idle with filler bytes
    task automatic wait_idle();
        bit done;
        done = 1'b0;
        while (!done) begin
            do @(negedge i_clk);
            while (pending_bytes.size() != 0 || expected_reports.size() != 0);
            repeat (TAIL_CYCLES) @(negedge i_clk);
            if (pstate == ST_IDLE) done = 1'b1;
            else pending_bytes.push_back(8'h00);
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (push && !full) begin
            parse_rx_byte(i_rx_byte);
            pending_bytes.delete(0);
            bytes_taken++;
        end
        if (i_rst_n && pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            push      <= 1'b1;
            i_rx_byte <= pending_bytes[0];
        end else begin
            push      <= 1'b0;
            i_rx_byte <= 8'($urandom);
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_frame_report want;
        if (pop && !empty) begin
            reports_taken++;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual sum_ok %b",
                         $time, o_sum_ok);
                errors++;
            end else begin
                want = expected_reports.pop_front();
                check_field("sum_ok", 16'(want.sum_ok), 16'(o_sum_ok));
                check_field("turn_code", 16'(want.turn_code), 16'(o_turn_code));
                check_field("line_angle", 16'(want.line_angle), 16'(o_line_angle));
                check_field("x_direction", 16'(want.x_direction), 16'(o_x_direction));
                check_field("x_shift", want.x_shift, o_x_shift);
                check_field("y_direction", 16'(want.y_direction), 16'(o_y_direction));
                check_field("y_shift", want.y_shift, o_y_shift);
                check_field("arrived_flag", 16'(want.arrived_flag), 16'(o_arrived_flag));
                check_field("updates_seen", want.updates_seen, o_updates_seen);
            end
        end
        pop <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(negedge i_clk) begin
        if (bytes_taken + reports_taken + regs_written != last_seen) begin
            last_seen = bytes_taken + reports_taken + regs_written;
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int p;
        int made;
        int pick;
        int n;
        int cut;
        int r;
        logic [7:0] addr;
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] func;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset addresses (own 00, broadcast FF)
        pending_bytes.push_back(8'h55);
        pending_bytes.push_back(vfr_pkg::FRAME_HEADER);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(vfr_pkg::VISION_IDENT);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(vfr_pkg::FRAME_HEADER);  // eaten by zero length, not a header
        pending_bytes.push_back(vfr_pkg::FRAME_HEADER);
        pending_bytes.push_back(8'h77);
        pending_bytes.push_back(vfr_pkg::FRAME_HEADER);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h05);
        pending_bytes.push_back(vfr_pkg::LENGTH_LIMIT);
        make_frame(8'hFF, vfr_pkg::VISION_IDENT, 8'd1, vfr_pkg::FUNC_ARRIVED, 1'b0);
        enqueue_frame(frame_bytes.size());
        make_frame(8'h00, vfr_pkg::VISION_IDENT, 8'd1, vfr_pkg::FUNC_LINE, 1'b1);
        enqueue_frame(frame_bytes.size());
        wait_idle();

        for (p = 0; p < NUM_PHASES; p++) begin
            write_reg(vfr_pkg::CFG_OWN_ADDR, own_tab[p]);
            write_reg(vfr_pkg::CFG_BCAST_ADDR, bcast_tab[p]);
            @(negedge i_clk);
            send_idle_pct  = send_tab[p];
            recv_stall_pct = recv_tab[p];
            made = 0;
            while (made < PHASE_BYTES) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    n = $urandom_range(3, 1);
                    repeat (n)
                        pending_bytes.push_back(($urandom_range(3) == 0) ?
                                                vfr_pkg::FRAME_HEADER : 8'($urandom));
                    made += n;
                end else begin
                    r = $urandom_range(9);
                    addr = (r < 4) ? own_addr : (r < 8) ? bcast_addr : 8'($urandom);
                    id = ($urandom_range(3) != 0) ? vfr_pkg::VISION_IDENT : 8'($urandom);
                    r = $urandom_range(99);
                    if (r < 3) len = 8'($urandom_range(249, 9));
                    else if (r < 13) len = 8'd0;
                    else len = 8'($urandom_range(8, 1));
                    func = ($urandom_range(99) < 85) ? 8'($urandom_range(3)) : 8'($urandom);
                    make_frame(addr, id, len, func, $urandom_range(99) < 15);
                    cut = frame_bytes.size();
                    if (pick < 16) cut = $urandom_range(frame_bytes.size() - 1, 1);
                    enqueue_frame(cut);
                    made += cut;
                end
            end
            wait_idle();
        end

        if (errors == 0 && expected_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
